@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("Same-cycle assertion failed.");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("Next-cycle assertion failed.");

`endif

@@ rtl/core/ttcs_pkg.sv @@
package ttcs_pkg;

  localparam int DEF_COLS         = 80;
  localparam int DEF_VISIBLE_ROWS = 45;
  localparam int DEF_TOTAL_ROWS   = 136;
  localparam int DEF_FONT_SIZE    = 16;
  localparam int DEF_SCREEN_WIDTH = 1280;

  localparam int BYTES_PER_PIXEL = 2;
  localparam int QUEUE_DEPTH     = 2;

  localparam int CHAR_W  = 8;
  localparam int GLYPH_W = 7;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 8;
  localparam int COLOR_W = 16;
  localparam int ADDR_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int CNT_W   = 3;

  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_NL    = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_TILDE = 8'd126;

  localparam logic [CNT_W-1:0] TAB_STOP = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_FG   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE = 2'd2;

  localparam logic [COLOR_W-1:0] FG_RESET = 16'hFFFF;

  typedef enum logic [1:0] {
    ACT_DRAW   = 2'd0,
    ACT_SCROLL = 2'd1,
    ACT_RESET  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_NL,
    OP_CR,
    OP_BS,
    OP_TAB,
    OP_IGN
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [GLYPH_W-1:0] glyph;
  } cmd_t;

  typedef struct packed {
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    logic [ADDR_W-1:0]  base;
  } cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_LINE
  } back_state_t;

endpackage

@@ rtl/core/ttcs_ifs.sv @@
interface ttcs_in_if import ttcs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

interface ttcs_out_if import ttcs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [COL_W-1:0]   cell_col;
  logic [ROW_W-1:0]   cell_row;
  logic [GLYPH_W-1:0] glyph;
  logic [COLOR_W-1:0] glyph_fg;
  logic [COLOR_W-1:0] glyph_bg;
  logic [ROW_W-1:0]   window_row;
  logic [ADDR_W-1:0]  show_address;
  logic [COL_W-1:0]   cur_col;
  logic [ROW_W-1:0]   cur_row;
  logic               last;

  modport source (output valid, output action, output cell_col, output cell_row,
                  output glyph, output glyph_fg, output glyph_bg, output window_row,
                  output show_address, output cur_col, output cur_row, output last,
                  input ready);
  modport sink   (input valid, input action, input cell_col, input cell_row,
                  input glyph, input glyph_fg, input glyph_bg, input window_row,
                  input show_address, input cur_col, input cur_row, input last,
                  output ready);
endinterface

interface ttcs_cfg_if import ttcs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/ttcs_regs.sv @@
module ttcs_regs import ttcs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ttcs_cfg_if.sink   cfg,
  output cfg_t       cfg_o
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg.ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg.valid) begin
      unique case (cfg.index)
        CFG_FG:   cfg_nxt.fg   = cfg.data[COLOR_W-1:0];
        CFG_BG:   cfg_nxt.bg   = cfg.data[COLOR_W-1:0];
        CFG_BASE: cfg_nxt.base = cfg.data[ADDR_W-1:0];
        default:  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fg   <= FG_RESET;
      cfg_r.bg   <= '0;
      cfg_r.base <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ rtl/core/ttcs_front.sv @@
module ttcs_front import ttcs_pkg::*; (
  ttcs_in_if.sink  in,
  input  logic     full,
  output logic     push,
  output cmd_t     push_cmd
);

  assign in.ready = !full;
  assign push     = in.valid && !full;

  always_comb begin
    push_cmd.glyph = in.char_in[GLYPH_W-1:0];
    if (in.char_in == CHAR_NL) begin
      push_cmd.op = OP_NL;
    end else if (in.char_in == CHAR_CR) begin
      push_cmd.op = OP_CR;
    end else if (in.char_in == CHAR_BS) begin
      push_cmd.op = OP_BS;
    end else if (in.char_in == CHAR_TAB) begin
      push_cmd.op = OP_TAB;
    end else if (in.char_in >= CHAR_SPACE && in.char_in <= CHAR_TILDE) begin
      push_cmd.op = OP_PUT;
    end else begin
      push_cmd.op = OP_IGN;
    end
  end

endmodule

@@ rtl/core/ttcs_queue.sv @@
module ttcs_queue import ttcs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0] count_r, count_nxt;
  logic              do_pop;

  assign full       = (count_r == CNT_QW'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ rtl/core/ttcs_back.sv @@
module ttcs_back import ttcs_pkg::*; #(
  parameter int COLS         = DEF_COLS,
  parameter int VISIBLE_ROWS = DEF_VISIBLE_ROWS,
  parameter int TOTAL_ROWS   = DEF_TOTAL_ROWS,
  parameter int FONT_SIZE    = DEF_FONT_SIZE,
  parameter int SCREEN_WIDTH = DEF_SCREEN_WIDTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       head_valid,
  input  cmd_t       head_cmd,
  output logic       pop,
  ttcs_out_if.source out
);

  localparam logic [ADDR_W-1:0] ROW_BYTES =
    ADDR_W'(FONT_SIZE * SCREEN_WIDTH * BYTES_PER_PIXEL);

  back_state_t        state_r, state_nxt;
  op_t                op_r, op_nxt;
  logic [GLYPH_W-1:0] glyph_r, glyph_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  action_t            pend_r, pend_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [ROW_W-1:0]   win_r, win_nxt;
  logic [ADDR_W-1:0]  offs_r, offs_nxt;

  logic               ov_r, ov_nxt;
  action_t            o_act_r, o_act_nxt;
  logic [COL_W-1:0]   o_col_r, o_col_nxt;
  logic [ROW_W-1:0]   o_row_r, o_row_nxt;
  logic [GLYPH_W-1:0] o_glyph_r, o_glyph_nxt;
  logic [COLOR_W-1:0] o_fg_r, o_fg_nxt;
  logic [COLOR_W-1:0] o_bg_r, o_bg_nxt;
  logic [ROW_W-1:0]   o_win_r;
  logic [ADDR_W-1:0]  o_addr_r;
  logic [COL_W-1:0]   o_ccol_r;
  logic [ROW_W-1:0]   o_crow_r;
  logic               o_last_r, o_last_nxt;
  logic               emit;

  logic               can_emit;
  logic [ROW_W:0]     nl_row_inc;
  logic [ROW_W:0]     win_lim;
  action_t            nl_act;
  logic [ROW_W-1:0]   nl_row;
  logic [ROW_W-1:0]   nl_win;
  logic [ADDR_W-1:0]  nl_offs;
  logic [COL_W:0]     col_inc;
  logic               wrap;

  assign can_emit   = !ov_r || out.ready;
  assign nl_row_inc = {1'b0, row_r} + 1'b1;
  assign win_lim    = {1'b0, win_r} + (ROW_W+1)'(VISIBLE_ROWS);
  assign col_inc    = {1'b0, col_r} + 1'b1;
  assign wrap       = (col_inc >= (COL_W+1)'(COLS));

  always_comb begin
    if (nl_row_inc >= (ROW_W+1)'(TOTAL_ROWS)) begin
      nl_act  = ACT_RESET;
      nl_row  = '0;
      nl_win  = '0;
      nl_offs = '0;
    end else if (nl_row_inc >= win_lim) begin
      nl_act  = ACT_SCROLL;
      nl_row  = nl_row_inc[ROW_W-1:0];
      nl_win  = win_r + 1'b1;
      nl_offs = offs_r + ROW_BYTES;
    end else begin
      nl_act  = ACT_NONE;
      nl_row  = nl_row_inc[ROW_W-1:0];
      nl_win  = win_r;
      nl_offs = offs_r;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    glyph_nxt   = glyph_r;
    cnt_nxt     = cnt_r;
    pend_nxt    = pend_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    win_nxt     = win_r;
    offs_nxt    = offs_r;
    pop         = 1'b0;
    emit        = 1'b0;
    o_act_nxt   = ACT_NONE;
    o_col_nxt   = '0;
    o_row_nxt   = '0;
    o_glyph_nxt = '0;
    o_fg_nxt    = '0;
    o_bg_nxt    = '0;
    o_last_nxt  = 1'b1;

    unique case (state_r)
      BK_IDLE: begin
        if (head_valid) begin
          pop       = 1'b1;
          op_nxt    = head_cmd.op;
          glyph_nxt = head_cmd.glyph;
          cnt_nxt   = (head_cmd.op == OP_TAB) ? TAB_STOP - {1'b0, col_r[1:0]} : CNT_W'(1);
          state_nxt = BK_RUN;
        end
      end

      BK_RUN: begin
        if (can_emit) begin
          emit = 1'b1;
          unique case (op_r)
            OP_PUT, OP_TAB: begin
              o_act_nxt   = ACT_DRAW;
              o_col_nxt   = col_r;
              o_row_nxt   = row_r;
              o_glyph_nxt = (op_r == OP_TAB) ? CHAR_SPACE[GLYPH_W-1:0] : glyph_r;
              o_fg_nxt    = cfg.fg;
              o_bg_nxt    = cfg.bg;
              if (wrap) begin
                col_nxt  = '0;
                row_nxt  = nl_row;
                win_nxt  = nl_win;
                offs_nxt = nl_offs;
              end else begin
                col_nxt = col_inc[COL_W-1:0];
              end
              if (wrap && nl_act != ACT_NONE) begin
                pend_nxt   = nl_act;
                o_last_nxt = 1'b0;
                state_nxt  = BK_LINE;
              end else begin
                o_last_nxt = (cnt_r == CNT_W'(1));
                cnt_nxt    = cnt_r - 1'b1;
                if (cnt_r == CNT_W'(1)) begin
                  state_nxt = BK_IDLE;
                end
              end
            end
            OP_NL: begin
              col_nxt   = '0;
              row_nxt   = nl_row;
              win_nxt   = nl_win;
              offs_nxt  = nl_offs;
              o_act_nxt = nl_act;
              if (nl_act == ACT_SCROLL) begin
                o_row_nxt = nl_row;
                o_bg_nxt  = cfg.bg;
              end
              state_nxt = BK_IDLE;
            end
            OP_CR: begin
              col_nxt   = '0;
              state_nxt = BK_IDLE;
            end
            OP_BS: begin
              if (col_r != '0) begin
                col_nxt     = col_r - 1'b1;
                o_act_nxt   = ACT_DRAW;
                o_col_nxt   = col_r - 1'b1;
                o_row_nxt   = row_r;
                o_glyph_nxt = CHAR_SPACE[GLYPH_W-1:0];
                o_fg_nxt    = cfg.fg;
                o_bg_nxt    = cfg.bg;
              end
              state_nxt = BK_IDLE;
            end
            default: begin
              state_nxt = BK_IDLE;
            end
          endcase
        end
      end

      BK_LINE: begin
        if (can_emit) begin
          emit      = 1'b1;
          o_act_nxt = pend_r;
          if (pend_r == ACT_SCROLL) begin
            o_row_nxt = row_r;
            o_bg_nxt  = cfg.bg;
          end
          o_last_nxt = (cnt_r == CNT_W'(1));
          cnt_nxt    = cnt_r - 1'b1;
          state_nxt  = (cnt_r == CNT_W'(1)) ? BK_IDLE : BK_RUN;
        end
      end

      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    if (emit) begin
      ov_nxt = 1'b1;
    end else if (out.ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      op_r    <= OP_IGN;
      cnt_r   <= '0;
      pend_r  <= ACT_NONE;
      col_r   <= '0;
      row_r   <= '0;
      win_r   <= '0;
      offs_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      win_r   <= win_nxt;
      offs_r  <= offs_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    glyph_r <= glyph_nxt;
    if (emit) begin
      o_act_r   <= o_act_nxt;
      o_col_r   <= o_col_nxt;
      o_row_r   <= o_row_nxt;
      o_glyph_r <= o_glyph_nxt;
      o_fg_r    <= o_fg_nxt;
      o_bg_r    <= o_bg_nxt;
      o_win_r   <= win_nxt;
      o_addr_r  <= cfg.base + offs_nxt;
      o_ccol_r  <= col_nxt;
      o_crow_r  <= row_nxt;
      o_last_r  <= o_last_nxt;
    end
  end

  assign out.valid        = ov_r;
  assign out.action       = o_act_r;
  assign out.cell_col     = o_col_r;
  assign out.cell_row     = o_row_r;
  assign out.glyph        = o_glyph_r;
  assign out.glyph_fg     = o_fg_r;
  assign out.glyph_bg     = o_bg_r;
  assign out.window_row   = o_win_r;
  assign out.show_address = o_addr_r;
  assign out.cur_col      = o_ccol_r;
  assign out.cur_row      = o_crow_r;
  assign out.last         = o_last_r;

endmodule

@@ rtl/core/text_terminal_cursor_scroller_unit.sv @@
// An item that enters an idle block passes through a queue slot and the idle-state fetch
// into the output register, where its first result is then valid. The execution sequencer
// takes each command from the two-entry queue and emits its results one at a time, taking
// the next command only after the last result; output stalls hold it. A tab yields at most
// five results. Reset (rst_n low at a clock edge) clears the cursor, the window, the queue
// and the output valid flag, and sets the foreground to white, the background and the base to zero.
module text_terminal_cursor_scroller_unit import ttcs_pkg::*; #(
  parameter int COLS         = DEF_COLS,
  parameter int VISIBLE_ROWS = DEF_VISIBLE_ROWS,
  parameter int TOTAL_ROWS   = DEF_TOTAL_ROWS,
  parameter int FONT_SIZE    = DEF_FONT_SIZE,
  parameter int SCREEN_WIDTH = DEF_SCREEN_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  ttcs_in_if.sink     in_ch,
  ttcs_out_if.source  out_ch,
  ttcs_cfg_if.sink    cfg_ch
);

  cfg_t cfg;
  logic q_full;
  logic q_push;
  cmd_t q_push_cmd;
  logic q_pop;
  logic q_head_valid;
  cmd_t q_head_cmd;

  ttcs_regs u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_ch),
    .cfg_o (cfg)
  );

  ttcs_front u_front (
    .in       (in_ch),
    .full     (q_full),
    .push     (q_push),
    .push_cmd (q_push_cmd)
  );

  ttcs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd)
  );

  ttcs_back #(
    .COLS         (COLS),
    .VISIBLE_ROWS (VISIBLE_ROWS),
    .TOTAL_ROWS   (TOTAL_ROWS),
    .FONT_SIZE    (FONT_SIZE),
    .SCREEN_WIDTH (SCREEN_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd),
    .pop        (q_pop),
    .out        (out_ch)
  );

endmodule

@@ rtl/core/ttcs_checker.sv @@
`include "assert_macros.svh"

module ttcs_checker import ttcs_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_action,
  input logic [ROW_W-1:0]   out_cell_row,
  input logic [GLYPH_W-1:0] out_glyph,
  input logic [ROW_W-1:0]   out_window_row,
  input logic [ADDR_W-1:0]  out_show_address,
  input logic [COL_W-1:0]   out_cur_col,
  input logic [ROW_W-1:0]   out_cur_row,
  input logic               out_last
);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_action) && $stable(out_show_address))
  `ASSERT_IMPL(a_none_is_last, clk, rst_n, out_valid && out_action == ACT_NONE, out_last)
  `ASSERT_IMPL(a_scroll_row, clk, rst_n, out_valid && out_action == ACT_SCROLL, out_cur_col == '0 && out_cell_row == out_cur_row && out_glyph == '0)
  `ASSERT_IMPL(a_reset_home, clk, rst_n, out_valid && out_action == ACT_RESET, out_cur_col == '0 && out_cur_row == '0 && out_window_row == '0)

endmodule

bind text_terminal_cursor_scroller_unit ttcs_checker u_ttcs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_action       (out_ch.action),
  .out_cell_row     (out_ch.cell_row),
  .out_glyph        (out_ch.glyph),
  .out_window_row   (out_ch.window_row),
  .out_show_address (out_ch.show_address),
  .out_cur_col      (out_ch.cur_col),
  .out_cur_row      (out_ch.cur_row),
  .out_last         (out_ch.last)
);

@@ tb/text_terminal_cursor_scroller_unit_tb.sv @@
module text_terminal_cursor_scroller_unit_tb import ttcs_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ADDR_W-1:0] ROW_BYTES = DEF_FONT_SIZE * DEF_SCREEN_WIDTH * BYTES_PER_PIXEL;
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_ITEMS   = 10;
  localparam int DRAIN_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_PRINTED   = 40;

  typedef struct packed {
    action_t            action;
    logic [COL_W-1:0]   cell_col;
    logic [ROW_W-1:0]   cell_row;
    logic [GLYPH_W-1:0] glyph;
    logic [COLOR_W-1:0] glyph_fg;
    logic [COLOR_W-1:0] glyph_bg;
    logic [ROW_W-1:0]   window_row;
    logic [ADDR_W-1:0]  show_address;
    logic [COL_W-1:0]   cur_col;
    logic [ROW_W-1:0]   cur_row;
    logic               last;
  } display_action_t;

  logic clk;
  logic rst_n;

  ttcs_in_if  in_if();
  ttcs_out_if out_if();
  ttcs_cfg_if cfg_if();

  text_terminal_cursor_scroller_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  display_action_t pending_actions[$];
  int mismatch_count;
  bit gaps_on;
  bit stalls_on;

  int cursor_col;
  int cursor_row;
  int window_top;
  logic [COLOR_W-1:0] fg_reg;
  logic [COLOR_W-1:0] bg_reg;
  logic [ADDR_W-1:0]  base_reg;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic [ADDR_W-1:0] got,
                               input logic [ADDR_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  function automatic void push_action(input action_t act, input int col, input int row,
                                      input logic [GLYPH_W-1:0] g,
                                      input logic [COLOR_W-1:0] fg,
                                      input logic [COLOR_W-1:0] bg);
    display_action_t a;
    a.action       = act;
    a.cell_col     = COL_W'(col);
    a.cell_row     = ROW_W'(row);
    a.glyph        = g;
    a.glyph_fg     = fg;
    a.glyph_bg     = bg;
    a.window_row   = ROW_W'(window_top);
    a.show_address = base_reg + ADDR_W'(window_top) * ROW_BYTES;
    a.cur_col      = COL_W'(cursor_col);
    a.cur_row      = ROW_W'(cursor_row);
    a.last         = 1'b0;
    pending_actions.push_back(a);
  endfunction

  function automatic action_t advance_line();
    cursor_col = 0;
    cursor_row++;
    if (cursor_row >= DEF_TOTAL_ROWS) begin
      cursor_row = 0;
      window_top = 0;
      return ACT_RESET;
    end
    if (cursor_row >= window_top + DEF_VISIBLE_ROWS) begin
      window_top++;
      return ACT_SCROLL;
    end
    return ACT_NONE;
  endfunction

  function automatic void push_line_action(input action_t act);
    if (act == ACT_SCROLL) begin
      push_action(ACT_SCROLL, 0, cursor_row, '0, '0, bg_reg);
    end else if (act == ACT_RESET) begin
      push_action(ACT_RESET, 0, 0, '0, '0, '0);
    end
  endfunction

  function automatic void draw_glyph(input logic [GLYPH_W-1:0] g);
    int col;
    int row;
    action_t wrap;
    col = cursor_col;
    row = cursor_row;
    wrap = ACT_NONE;
    cursor_col++;
    if (cursor_col >= DEF_COLS) begin
      wrap = advance_line();
    end
    push_action(ACT_DRAW, col, row, g, fg_reg, bg_reg);
    push_line_action(wrap);
  endfunction

  function automatic void predict_char(input logic [CHAR_W-1:0] c);
    int first;
    int spaces;
    display_action_t tail;
    first = pending_actions.size();
    if (c == CHAR_NL) begin
      push_line_action(advance_line());
    end else if (c == CHAR_CR) begin
      cursor_col = 0;
    end else if (c == CHAR_BS) begin
      if (cursor_col > 0) begin
        cursor_col--;
        push_action(ACT_DRAW, cursor_col, cursor_row, CHAR_SPACE[GLYPH_W-1:0], fg_reg, bg_reg);
      end
    end else if (c == CHAR_TAB) begin
      spaces = int'(TAB_STOP) - cursor_col % int'(TAB_STOP);
      repeat (spaces) draw_glyph(CHAR_SPACE[GLYPH_W-1:0]);
    end else if (c >= CHAR_SPACE && c <= CHAR_TILDE) begin
      draw_glyph(c[GLYPH_W-1:0]);
    end
    if (pending_actions.size() == first) begin
      push_action(ACT_NONE, 0, 0, '0, '0, '0);
    end
    tail = pending_actions.pop_back();
    tail.last = 1'b1;
    pending_actions.push_back(tail);
  endfunction

  task automatic send_char(input logic [CHAR_W-1:0] c);
    int gap;
    gap = gaps_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.char_in <= c;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    predict_char(c);
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    in_if.valid <= 1'b0;
    while (pending_actions.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg,
                           input logic [ADDR_W-1:0] base);
    logic [CFG_DATA_W-1:0] values [3];
    logic [CFG_IDX_W-1:0]  regs [3];
    values[0] = {16'($urandom), fg};
    values[1] = {16'($urandom), bg};
    values[2] = base;
    regs[0] = CFG_FG;
    regs[1] = CFG_BG;
    regs[2] = CFG_BASE;
    for (int i = 0; i < 3; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= regs[i];
      cfg_if.data  <= values[i];
      do @(posedge clk); while (cfg_if.ready !== 1'b1);
    end
    cfg_if.valid <= 1'b0;
    fg_reg   = fg;
    bg_reg   = bg;
    base_reg = base;
  endtask

  task automatic newlines_to_row(input int row);
    while (cursor_row != row) send_char(CHAR_NL);
  endtask

  function automatic logic [CHAR_W-1:0] random_char(input int nl_pct);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < nl_pct) return CHAR_NL;
    if (pick < nl_pct + 8) return CHAR_TAB;
    if (pick < nl_pct + 15) return CHAR_BS;
    if (pick < nl_pct + 19) return CHAR_CR;
    if (pick < nl_pct + 35) return CHAR_W'($urandom_range(0, 255));
    return CHAR_W'($urandom_range(32, 126));
  endfunction

  task automatic test_ignored_bytes();
    send_char(8'h00);
    send_char(8'hFF);
    send_char(8'h7F);
    send_char(8'h80);
    send_char(8'h1F);
    send_char(8'h01);
    send_char(CHAR_CR);
    send_char(CHAR_BS);
    settle();
  endtask

  task automatic test_printables();
    configure(16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
    send_char(CHAR_SPACE);
    send_char(CHAR_TILDE);
    send_char("A");
    send_char(CHAR_BS);
    send_char(CHAR_BS);
    send_char(CHAR_BS);
    send_char(CHAR_BS);
    send_char(CHAR_TAB);
    send_char("x");
    send_char(CHAR_TAB);
    send_char(CHAR_NL);
    send_char(CHAR_CR);
    settle();
  endtask

  task automatic test_line_wrap();
    configure(16'hFFFF, 16'h0000, 32'h0000_0000);
    send_char(CHAR_CR);
    repeat (DEF_COLS / 4) send_char(CHAR_TAB);
    repeat (DEF_COLS - 1) send_char(CHAR_W'($urandom_range(32, 126)));
    send_char("q");
    settle();
  endtask

  task automatic test_scroll();
    configure(16'($urandom), 16'($urandom), $urandom);
    newlines_to_row(window_top + DEF_VISIBLE_ROWS - 1);
    send_char(CHAR_NL);
    send_char(CHAR_NL);
    repeat (DEF_COLS / 4 - 1) send_char(CHAR_TAB);
    send_char("a");
    send_char("b");
    send_char("c");
    send_char("d");
    settle();
  endtask

  task automatic test_buffer_reset();
    configure(16'h5A5A, 16'hA5A5, 32'hFFFF_0000);
    newlines_to_row(DEF_TOTAL_ROWS - 1);
    repeat (DEF_COLS / 4) send_char(CHAR_TAB);
    settle();
    newlines_to_row(DEF_TOTAL_ROWS - 1);
    send_char(CHAR_NL);
    settle();
  endtask

  task automatic test_random_text();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      unique case (phase)
        0: configure(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        1: configure(16'h0000, 16'h0000, 32'h0000_0000);
        default: configure(16'($urandom), 16'($urandom), $urandom);
      endcase
      gaps_on   = (phase != 1) && (phase != 3);
      stalls_on = (phase != 1) && (phase != 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_char(random_char(phase == 0 ? 30 : 15));
      end
      settle();
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin : display_monitor
    int stall;
    display_action_t want;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = stalls_on ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
      if (pending_actions.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, action %0d", out_if.action));
      end else begin
        want = pending_actions.pop_front();
        compare_field("action", ADDR_W'(out_if.action), ADDR_W'(want.action));
        compare_field("cell_col", ADDR_W'(out_if.cell_col), ADDR_W'(want.cell_col));
        compare_field("cell_row", ADDR_W'(out_if.cell_row), ADDR_W'(want.cell_row));
        compare_field("glyph", ADDR_W'(out_if.glyph), ADDR_W'(want.glyph));
        compare_field("glyph_fg", ADDR_W'(out_if.glyph_fg), ADDR_W'(want.glyph_fg));
        compare_field("glyph_bg", ADDR_W'(out_if.glyph_bg), ADDR_W'(want.glyph_bg));
        compare_field("window_row", ADDR_W'(out_if.window_row), ADDR_W'(want.window_row));
        compare_field("show_address", out_if.show_address, want.show_address);
        compare_field("cur_col", ADDR_W'(out_if.cur_col), ADDR_W'(want.cur_col));
        compare_field("cur_row", ADDR_W'(out_if.cur_row), ADDR_W'(want.cur_row));
        compare_field("last", ADDR_W'(out_if.last), ADDR_W'(want.last));
      end
    end
  end

  initial begin
    in_if.valid   <= 1'b0;
    in_if.char_in <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= CFG_FG;
    cfg_if.data   <= '0;
    rst_n         <= 1'b0;
    mismatch_count = 0;
    gaps_on    = 1'b1;
    stalls_on  = 1'b1;
    cursor_col = 0;
    cursor_row = 0;
    window_top = 0;
    fg_reg     = FG_RESET;
    bg_reg     = '0;
    base_reg   = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_ignored_bytes();
    test_printables();
    test_line_wrap();
    test_scroll();
    test_buffer_reset();
    test_random_text();

    settle();
    if (pending_actions.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never came", pending_actions.size()));
    end
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding.", pending_actions.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ text_terminal_cursor_scroller_unit.f @@
+incdir+rtl/core
rtl/core/ttcs_pkg.sv
rtl/core/ttcs_ifs.sv
rtl/core/ttcs_regs.sv
rtl/core/ttcs_front.sv
rtl/core/ttcs_queue.sv
rtl/core/ttcs_back.sv
rtl/core/text_terminal_cursor_scroller_unit.sv
rtl/core/ttcs_checker.sv
tb/text_terminal_cursor_scroller_unit_tb.sv
